### rtl/slxfp_pkg.sv
package slxfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 2;

  localparam logic [LenW-1:0] MaxLengthReset = 16'd1124;

  localparam logic [KindW-1:0] KindPayload = 2'd0;
  localparam logic [KindW-1:0] KindGood    = 2'd1;
  localparam logic [KindW-1:0] KindBad     = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  byte_index;
    logic [LenW-1:0]  frame_length;
  } result_t;

endpackage

### rtl/slxfp_parser.sv
module slxfp_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [slxfp_pkg::ByteW-1:0]   byte_i,
  input  logic                          resync_i,
  input  logic [slxfp_pkg::LenW-1:0]    max_length_i,
  output logic                          res_valid_o,
  output slxfp_pkg::result_t            res_o
);

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhSync2   = 3'd1;
  localparam logic [2:0] PhLenHi   = 3'd2;
  localparam logic [2:0] PhLenLo   = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhCheck   = 3'd5;

  localparam logic [slxfp_pkg::ByteW-1:0] SyncFirst  = 8'hAA;
  localparam logic [slxfp_pkg::ByteW-1:0] SyncSecond = 8'h55;

  logic [2:0]                      phase_q, phase_d;
  logic [slxfp_pkg::LenW-1:0]      len_q, len_d;
  logic [slxfp_pkg::LenW-1:0]      left_q, left_d;
  logic [slxfp_pkg::ByteW-1:0]     xor_q, xor_d;
  logic [2:0]                      phase_eff;

  always_comb begin
    phase_eff   = resync_i ? PhHunt : phase_q;
    phase_d     = phase_eff;
    len_d       = len_q;
    left_d      = left_q;
    xor_d       = xor_q;
    res_valid_o = 1'b0;
    res_o.kind         = slxfp_pkg::KindPayload;
    res_o.payload_byte = '0;
    res_o.byte_index   = '0;
    res_o.frame_length = len_q;
    unique case (phase_eff)
      PhHunt: begin
        if (byte_i == SyncFirst) phase_d = PhSync2;
      end
      PhSync2: begin
        if (byte_i == SyncSecond) begin
          phase_d = PhLenHi;
          xor_d   = '0;
          len_d   = '0;
        end else begin
          phase_d = PhHunt;
        end
      end
      PhLenHi: begin
        len_d   = {{(slxfp_pkg::LenW-slxfp_pkg::ByteW){1'b0}}, byte_i};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d   = {len_q[slxfp_pkg::ByteW-1:0], byte_i};
        left_d  = {len_q[slxfp_pkg::ByteW-1:0], byte_i};
        phase_d = PhPayload;
      end
      PhPayload: begin
        // A zero or over-long length swallows this byte and drops the frame.
        if (len_q == '0 || len_q > max_length_i) begin
          phase_d = PhHunt;
        end else begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = byte_i;
          res_o.byte_index   = len_q - left_q;
          xor_d              = xor_q ^ byte_i;
          if (left_q <= 16'd1) phase_d = PhCheck;
          left_d             = left_q - 16'd1;
        end
      end
      PhCheck: begin
        res_valid_o = 1'b1;
        res_o.kind  = (byte_i == xor_q) ? slxfp_pkg::KindGood : slxfp_pkg::KindBad;
        phase_d     = PhHunt;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      left_q  <= '0;
      xor_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      left_q  <= left_d;
      xor_q   <= xor_d;
    end
  end

endmodule

### rtl/sync_length_xor_frame_parser_core.sv
// A result is registered and appears on the master side in the cycle after its input byte is accepted.
// Throughput: one byte per cycle while the output register is empty or being drained; the frame state
// updates once per accepted byte, and the output register accepts a new byte while its result is being taken.
// Reset (rst_ni low, asynchronous): the parser hunts for the first sync byte, the output
// register is empty and max_length returns to 1124.
module sync_length_xor_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic        s_axis_tuser,  // [0] resync
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [7:0] payload_byte, [23:8] byte_index,
                                     // [39:24] frame_length
  output logic [1:0]  m_axis_tuser   // [1:0] kind
);

  logic [slxfp_pkg::LenW-1:0] max_length_q;
  logic                       accept;
  logic                       res_valid;
  slxfp_pkg::result_t         res;
  slxfp_pkg::result_t         out_q;
  logic                       out_valid_q, out_valid_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= slxfp_pkg::MaxLengthReset;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  slxfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .byte_i       (s_axis_tdata),
    .resync_i     (s_axis_tuser),
    .max_length_i (max_length_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.frame_length, out_q.byte_index, out_q.payload_byte};
  assign m_axis_tuser  = out_q.kind;

`ifndef ASSERT_OFF
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == slxfp_pkg::KindPayload ||
                       m_axis_tuser == slxfp_pkg::KindGood ||
                       m_axis_tuser == slxfp_pkg::KindBad))
    else $error("illegal result kind");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == slxfp_pkg::KindPayload) |->
      (m_axis_tdata[23:8] < m_axis_tdata[39:24]))
    else $error("payload index outside declared length");

  a_end_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != slxfp_pkg::KindPayload) |->
      (m_axis_tdata[23:0] == 24'd0))
    else $error("end result carries payload data");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");
`endif

endmodule

### tb/deframe_scoreboard.sv
package deframe_tb_pkg;
  import slxfp_pkg::*;

  localparam logic [7:0] SyncFirst  = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;

  typedef enum logic [2:0] {
    HuntFirst,
    HuntSecond,
    LenHigh,
    LenLow,
    Payload,
    Checksum
  } parse_phase_e;

  class deframe_scoreboard;
    logic [15:0]  max_len;
    parse_phase_e phase;
    logic [15:0]  frame_len;
    logic [15:0]  bytes_left;
    logic [7:0]   running_xor;
    result_t      expected_results[$];
    int           errors;

    function new();
      max_len     = MaxLengthReset;
      phase       = HuntFirst;
      frame_len   = '0;
      bytes_left  = '0;
      running_xor = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advances the parser by one received byte and queues the result it causes, if any.
    function void note_rx_byte(logic [7:0] value, logic resync);
      result_t res;
      res = '0;
      if (resync) phase = HuntFirst;
      case (phase)
        HuntFirst: begin
          if (value == SyncFirst) phase = HuntSecond;
        end
        HuntSecond: begin
          if (value == SyncSecond) begin
            phase       = LenHigh;
            running_xor = '0;
            frame_len   = '0;
          end else begin
            phase = HuntFirst;
          end
        end
        LenHigh: begin
          frame_len = {8'h00, value};
          phase     = LenLow;
        end
        LenLow: begin
          frame_len  = {frame_len[7:0], value};
          bytes_left = frame_len;
          phase      = Payload;
        end
        Payload: begin
          // A zero or over-long length swallows the first payload byte and drops the frame.
          if (frame_len == 16'd0 || frame_len > max_len) begin
            phase = HuntFirst;
          end else begin
            res.kind         = KindPayload;
            res.payload_byte = value;
            res.byte_index   = frame_len - bytes_left;
            res.frame_length = frame_len;
            expected_results.push_back(res);
            running_xor = running_xor ^ value;
            if (bytes_left <= 16'd1) phase = Checksum;
            bytes_left = bytes_left - 16'd1;
          end
        end
        Checksum: begin
          res.kind         = (value == running_xor) ? KindGood : KindBad;
          res.frame_length = frame_len;
          expected_results.push_back(res);
          phase = HuntFirst;
        end
        default: begin
          phase = HuntFirst;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none pending, expected nothing actual kind %0d byte 0x%0h",
                 $time, got.kind, got.payload_byte);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

endpackage

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slxfp_pkg::*;
  import deframe_tb_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldOffCycles = 400;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  deframe_scoreboard sb = new();
  int   bytes_sent   = 0;
  int   burst_left   = 0;
  int   quiet_cycles = 0;
  logic hold_req     = 1'b0;

  // {resync, byte}: noise, a broken sync, a cut-short frame restarted by resync,
  // a bad checksum, a zero length and a length one above the reset maximum.
  logic [8:0] directed_bytes[$] = '{
    9'h0FF, 9'h0AA, 9'h0AA, 9'h055,
    9'h0AA, 9'h055, 9'h000, 9'h005, 9'h000,
    9'h1AA, 9'h055, 9'h000, 9'h001, 9'h0FF, 9'h0FF,
    9'h0AA, 9'h055, 9'h000, 9'h001, 9'h080, 9'h000,
    9'h0AA, 9'h055, 9'h000, 9'h000, 9'h033,
    9'h0AA, 9'h055, 9'h004, 9'h065, 9'h022
  };

  sync_length_xor_frame_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Results are checked before the input of the same edge is noted, so a result can
  // never be matched against the byte accepted together with it.
  always @(posedge clk_i) begin : monitor
    result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind         = m_axis_tuser;
        got.payload_byte = m_axis_tdata[7:0];
        got.byte_index   = m_axis_tdata[23:8];
        got.frame_length = m_axis_tdata[39:24];
        sb.check_result(got);
      end
      if (s_axis_tvalid && s_axis_tready) sb.note_rx_byte(s_axis_tdata, s_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: free-running stretches, random stalls, rare long stalls, and one
  // long hold-off on request so the block backs up into its input.
  initial begin : receiver
    int run;
    int sel;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      sel = $urandom_range(0, 9);
      run = (sel == 9) ? $urandom_range(10, 60) : $urandom_range(1, 30);
      repeat (run) begin
        if (sel < 3) begin
          m_axis_tready <= 1'b1;
        end else if (sel == 9) begin
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        @(posedge clk_i);
      end
    end
  end

  function automatic int next_gap();
    int sel;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 60);
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic resync);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= resync;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Sends sync, length and pay_count payload bytes; the checksum byte follows only
  // when the whole payload was sent.
  task automatic send_frame(input int len, input int pay_count, input bit corrupt,
                            input bit resync);
    logic [15:0] len_bits;
    logic [7:0]  sum;
    logic [7:0]  value;
    len_bits = len[15:0];
    sum      = '0;
    send_byte(SyncFirst, resync);
    send_byte(SyncSecond, 1'b0);
    send_byte(len_bits[15:8], 1'b0);
    send_byte(len_bits[7:0], 1'b0);
    for (int i = 0; i < pay_count; i++) begin
      value = 8'($urandom_range(0, 255));
      sum   = sum ^ value;
      send_byte(value, 1'b0);
    end
    if (pay_count == len) begin
      send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum, 1'b0);
    end
  endtask

  task automatic random_chunk();
    int sel;
    int lim;
    int len;
    int cap;
    sel = $urandom_range(0, 99);
    lim = int'(sb.max_len);
    cap = ($urandom_range(0, 9) == 0) ? 64 : 12;
    if (cap > lim) cap = lim;
    if (sel < 60 && lim != 0) begin
      len = $urandom_range(1, cap);
      send_frame(len, len, $urandom_range(0, 4) == 0, $urandom_range(0, 15) == 0);
    end else if (sel < 72) begin
      len = ($urandom_range(0, 3) == 0 || lim == 65535) ? 0 : $urandom_range(lim + 1, 65535);
      send_frame(len, $urandom_range(1, 3), 1'b0, 1'b0);
    end else if (sel < 84) begin
      // A frame cut off mid-payload, then a resync that starts the next one.
      len = $urandom_range(1, 12);
      send_frame(len, $urandom_range(0, len - 1), 1'b0, 1'b0);
      send_frame(len, len, 1'b0, 1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(($urandom_range(0, 3) == 0) ? SyncFirst : 8'($urandom_range(0, 255)),
                  $urandom_range(0, 9) == 0);
      end
    end
  endtask

  task automatic run_random(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) random_chunk();
  endtask

  // The length limit changes only with the input side quiet and all results drained.
  task automatic write_max_length(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_len = value;
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    run_random(100);

    write_max_length(16'd0);
    run_random(60);

    write_max_length(16'hFFFF);
    hold_req = 1'b1;
    send_frame(200, 200, 1'b0, 1'b0);
    run_random(100);

    write_max_length(16'd1);
    run_random(60);

    write_max_length(16'($urandom_range(2, 40)));
    run_random(100);

    write_max_length(16'($urandom_range(100, 2000)));
    run_random(80);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
